@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define CHK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/srcag_pkg.sv @@
// Shared types, constants and command codes of the strided region copy address generator.
package srcag_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int CNT_W       = $clog2(MAX_ROWS + 1);
    localparam int ROWS_W      = 2 * CNT_W;
    localparam int OFFS_W      = 32;
    localparam int ROW_BYTES_W = 23;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int STEP_W      = 4;

    localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS             = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_BYTES       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_ROW_STRIDE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_PLANE_STRIDE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_ROW_STRIDE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_PLANE_STRIDE = 3'd5;

    // Setup steps of the shared multiplier, in the order they run.
    localparam logic [STEP_W-1:0] MUL_FULL = 4'd0;  // extent_x * elem_bytes
    localparam logic [STEP_W-1:0] MUL_SXE  = 4'd1;  // src_x * elem_bytes
    localparam logic [STEP_W-1:0] MUL_DXE  = 4'd2;  // dst_x * elem_bytes
    localparam logic [STEP_W-1:0] MUL_SPL  = 4'd3;  // extent_y * source row stride
    localparam logic [STEP_W-1:0] MUL_DPL  = 4'd4;  // extent_y * destination row stride
    localparam logic [STEP_W-1:0] MUL_SYR  = 4'd5;  // src_y * source row stride
    localparam logic [STEP_W-1:0] MUL_DYR  = 4'd6;  // dst_y * destination row stride
    localparam logic [STEP_W-1:0] MUL_SZP  = 4'd7;  // src_z * source plane stride
    localparam logic [STEP_W-1:0] MUL_DZP  = 4'd8;  // dst_z * destination plane stride
    localparam logic [STEP_W-1:0] MUL_LAST = MUL_DZP;

    typedef struct packed {
        logic [15:0] src_x;
        logic [15:0] src_y;
        logic [15:0] src_z;
        logic [15:0] dst_x;
        logic [15:0] dst_y;
        logic [15:0] dst_z;
        logic [15:0] extent_x;
        logic [15:0] extent_y;
        logic [15:0] extent_z;
    } in_word_t;

    typedef struct packed {
        logic [OFFS_W-1:0]      src_offset;
        logic [OFFS_W-1:0]      dst_offset;
        logic [ROW_BYTES_W-1:0] row_bytes;
        logic                   last_row;
        logic                   too_many_rows;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load_item;
        logic              mul_en;
        logic [STEP_W-1:0] mul_sel;
        logic              sum;
        logic              load_row;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic too_many;
        logic last;
        logic out_free;
    } stat_t;

endpackage

@@ rtl/srcag_ctrl.sv @@
// Controller state machine: setup multiply steps, base sum and row emission.
module srcag_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  srcag_pkg::stat_t     stat,
    output srcag_pkg::cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;
    localparam logic [1:0] ST_ROW  = 2'd3;

    logic [1:0]                   state_reg;
    logic [1:0]                   state_next;
    logic [srcag_pkg::STEP_W-1:0] step_reg;
    logic [srcag_pkg::STEP_W-1:0] step_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        cmd           = '0;
        cmd.mul_sel   = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    step_next     = srcag_pkg::MUL_FULL;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                if (step_reg == srcag_pkg::MUL_LAST)
                begin
                    state_next = ST_SUM;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_ROW;
            end
            ST_ROW:
            begin
                if (stat.out_free)
                begin
                    cmd.load_row = 1'b1;
                    if (stat.too_many || stat.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= srcag_pkg::MUL_FULL;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

@@ rtl/srcag_dpath.sv @@
// Datapath: configuration registers, shared multiplier, offset walkers and output register.
module srcag_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  srcag_pkg::cmd_t                     cmd,
    output srcag_pkg::stat_t                    stat,
    input  logic                                cfg_we,
    input  logic [srcag_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [srcag_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  srcag_pkg::in_word_t                 in_word,
    output logic                                out_valid,
    input  logic                                out_stall,
    output srcag_pkg::out_word_t                out_word
);

    localparam int CNT_W  = srcag_pkg::CNT_W;
    localparam int ROWS_W = srcag_pkg::ROWS_W;
    localparam int OFFS_W = srcag_pkg::OFFS_W;

    // Configuration registers.
    logic [1:0]        dims_reg;
    logic [7:0]        elem_bytes_reg;
    logic [23:0]       src_row_stride_reg;
    logic [31:0]       src_plane_stride_reg;
    logic [23:0]       dst_row_stride_reg;
    logic [31:0]       dst_plane_stride_reg;

    srcag_pkg::in_word_t item_reg;

    // Setup products.
    logic [23:0]       full_reg;
    logic [23:0]       sxe_reg;
    logic [23:0]       dxe_reg;
    logic [31:0]       splt_reg;
    logic [31:0]       dplt_reg;
    logic [31:0]       syr_reg;
    logic [31:0]       dyr_reg;
    logic [31:0]       szp_reg;
    logic [31:0]       dzp_reg;

    logic [15:0]       mul_a;
    logic [31:0]       mul_b;
    logic [47:0]       mul_full;
    logic [31:0]       prod;

    logic [23:0]       srow;
    logic [23:0]       drow;
    logic [31:0]       splane;
    logic [31:0]       dplane;

    logic              use_rows;
    logic              use_planes;
    logic [15:0]       ny;
    logic [15:0]       nz;
    logic [ROWS_W-1:0] rows_small;
    logic [CNT_W-1:0]  ny_m1;
    logic [CNT_W-1:0]  nz_m1;
    logic              too_many;
    logic              last;

    logic [OFFS_W-1:0] src_base;
    logic [OFFS_W-1:0] dst_base;

    logic [OFFS_W-1:0] row_src_reg;
    logic [OFFS_W-1:0] row_dst_reg;
    logic [OFFS_W-1:0] slice_src_reg;
    logic [OFFS_W-1:0] slice_dst_reg;
    logic [CNT_W-1:0]  y_cnt_reg;
    logic [CNT_W-1:0]  z_cnt_reg;

    logic [srcag_pkg::ROW_BYTES_W-1:0] bytes;

    logic                  out_valid_reg;
    srcag_pkg::out_word_t  out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg             <= 2'd1;
            elem_bytes_reg       <= 8'd1;
            src_row_stride_reg   <= '0;
            src_plane_stride_reg <= '0;
            dst_row_stride_reg   <= '0;
            dst_plane_stride_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                srcag_pkg::CFG_DIMS:             dims_reg             <= cfg_data[1:0];
                srcag_pkg::CFG_ELEM_BYTES:       elem_bytes_reg       <= cfg_data[7:0];
                srcag_pkg::CFG_SRC_ROW_STRIDE:   src_row_stride_reg   <= cfg_data[23:0];
                srcag_pkg::CFG_SRC_PLANE_STRIDE: src_plane_stride_reg <= cfg_data[31:0];
                srcag_pkg::CFG_DST_ROW_STRIDE:   dst_row_stride_reg   <= cfg_data[23:0];
                srcag_pkg::CFG_DST_PLANE_STRIDE: dst_plane_stride_reg <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_word;
        end
    end

    // Zero strides fall back to tight packing.
    assign srow   = (src_row_stride_reg != '0) ? src_row_stride_reg : full_reg;
    assign drow   = (dst_row_stride_reg != '0) ? dst_row_stride_reg : full_reg;
    assign splane = (src_plane_stride_reg != '0) ? src_plane_stride_reg : splt_reg;
    assign dplane = (dst_plane_stride_reg != '0) ? dst_plane_stride_reg : dplt_reg;

    always_comb
    begin
        unique case (cmd.mul_sel)
            srcag_pkg::MUL_FULL: begin mul_a = item_reg.extent_x; mul_b = {24'd0, elem_bytes_reg}; end
            srcag_pkg::MUL_SXE:  begin mul_a = item_reg.src_x;    mul_b = {24'd0, elem_bytes_reg}; end
            srcag_pkg::MUL_DXE:  begin mul_a = item_reg.dst_x;    mul_b = {24'd0, elem_bytes_reg}; end
            srcag_pkg::MUL_SPL:  begin mul_a = item_reg.extent_y; mul_b = {8'd0, srow};            end
            srcag_pkg::MUL_DPL:  begin mul_a = item_reg.extent_y; mul_b = {8'd0, drow};            end
            srcag_pkg::MUL_SYR:  begin mul_a = item_reg.src_y;    mul_b = {8'd0, srow};            end
            srcag_pkg::MUL_DYR:  begin mul_a = item_reg.dst_y;    mul_b = {8'd0, drow};            end
            srcag_pkg::MUL_SZP:  begin mul_a = item_reg.src_z;    mul_b = splane;                  end
            srcag_pkg::MUL_DZP:  begin mul_a = item_reg.dst_z;    mul_b = dplane;                  end
            default:             begin mul_a = '0;                mul_b = '0;                      end
        endcase
    end

    assign mul_full = {32'd0, mul_a} * {16'd0, mul_b};
    assign prod     = mul_full[31:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            unique case (cmd.mul_sel)
                srcag_pkg::MUL_FULL: full_reg <= prod[23:0];
                srcag_pkg::MUL_SXE:  sxe_reg  <= prod[23:0];
                srcag_pkg::MUL_DXE:  dxe_reg  <= prod[23:0];
                srcag_pkg::MUL_SPL:  splt_reg <= prod;
                srcag_pkg::MUL_DPL:  dplt_reg <= prod;
                srcag_pkg::MUL_SYR:  syr_reg  <= prod;
                srcag_pkg::MUL_DYR:  dyr_reg  <= prod;
                srcag_pkg::MUL_SZP:  szp_reg  <= prod;
                srcag_pkg::MUL_DZP:  dzp_reg  <= prod;
                default:
                begin
                end
            endcase
        end
    end

    // Shape of the request.
    assign use_planes = (dims_reg >= 2'd3) && (item_reg.extent_y != '0)
                        && (item_reg.extent_z != '0);
    assign use_rows   = (dims_reg >= 2'd2) && (item_reg.extent_y != '0);
    assign ny         = use_rows ? item_reg.extent_y : 16'd1;
    assign nz         = use_planes ? item_reg.extent_z : 16'd1;
    assign rows_small = ROWS_W'(ny[CNT_W-1:0]) * ROWS_W'(nz[CNT_W-1:0]);
    assign too_many   = (ny > 16'(srcag_pkg::MAX_ROWS)) || (nz > 16'(srcag_pkg::MAX_ROWS))
                        || (rows_small > ROWS_W'(srcag_pkg::MAX_ROWS));
    assign ny_m1      = CNT_W'(ny - 16'd1);
    assign nz_m1      = CNT_W'(nz - 16'd1);
    assign last       = (y_cnt_reg == ny_m1) && (z_cnt_reg == nz_m1);

    assign src_base = {8'd0, sxe_reg} + (use_rows ? syr_reg : '0) + (use_planes ? szp_reg : '0);
    assign dst_base = {8'd0, dxe_reg} + (use_rows ? dyr_reg : '0) + (use_planes ? dzp_reg : '0);

    assign bytes = full_reg[23] ? srcag_pkg::ROW_BYTES_MAX : full_reg[22:0];

    // Row walker: step by the row stride, and by the plane stride at each new slice.
    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            row_src_reg   <= src_base;
            row_dst_reg   <= dst_base;
            slice_src_reg <= src_base;
            slice_dst_reg <= dst_base;
            y_cnt_reg     <= '0;
            z_cnt_reg     <= '0;
        end
        else if (cmd.load_row)
        begin
            if (y_cnt_reg == ny_m1)
            begin
                y_cnt_reg     <= '0;
                z_cnt_reg     <= z_cnt_reg + 1'b1;
                slice_src_reg <= slice_src_reg + splane;
                slice_dst_reg <= slice_dst_reg + dplane;
                row_src_reg   <= slice_src_reg + splane;
                row_dst_reg   <= slice_dst_reg + dplane;
            end
            else
            begin
                y_cnt_reg   <= y_cnt_reg + 1'b1;
                row_src_reg <= row_src_reg + {8'd0, srow};
                row_dst_reg <= row_dst_reg + {8'd0, drow};
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_row)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_row)
        begin
            if (too_many)
            begin
                out_word_reg.src_offset    <= '0;
                out_word_reg.dst_offset    <= '0;
                out_word_reg.row_bytes     <= '0;
                out_word_reg.last_row      <= 1'b1;
                out_word_reg.too_many_rows <= 1'b1;
            end
            else
            begin
                out_word_reg.src_offset    <= row_src_reg;
                out_word_reg.dst_offset    <= row_dst_reg;
                out_word_reg.row_bytes     <= bytes;
                out_word_reg.last_row      <= last;
                out_word_reg.too_many_rows <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_word      = out_word_reg;
    assign stat.too_many = too_many;
    assign stat.last     = last;
    assign stat.out_free = !out_valid_reg || !out_stall;

endmodule

@@ rtl/strided_region_copy_address_gen_top.sv @@
// Top level of the strided region copy address generator: controller plus datapath.
// The request word is registered, the nine steps of the one shared multiplier run, then the
// base sum, then the row words, one row word per cycle while out_stall is low. A request of
// R rows (error: one word) gives R row words; in_stall stays high until its last word is loaded.
// Reset (rst_n, asynchronous, active low) clears the controller and the output valid and loads
// the registers with dims 1, elem_bytes 1 and all strides zero.
module strided_region_copy_address_gen_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  srcag_pkg::in_word_t                in_word,
    output logic                               out_valid,
    input  logic                               out_stall,
    output srcag_pkg::out_word_t               out_word,
    input  logic                               cfg_we,
    input  logic [srcag_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srcag_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // The controller sequences the setup multiplies, one per cycle, then the base sum, then
    // issues one row load per cycle whenever the output register is free. The input side is
    // open again as soon as the last row word is loaded, even while that word still waits.
    srcag_pkg::cmd_t  cmd;
    srcag_pkg::stat_t stat;

    srcag_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the configuration, the request word, the setup products, the
    // running source and destination offsets and the output word register.
    srcag_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

@@ rtl/srcag_checker.sv @@
// Port-level checker for the strided region copy address generator, with its bind.
`include "assert_macros.svh"

module srcag_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  srcag_pkg::out_word_t  out_word
);

    logic out_held;
    logic in_accept;
    logic err_word;
    logic err_word_ok;

    assign out_held    = out_valid && out_stall;
    assign in_accept   = in_valid && !in_stall;
    assign err_word    = out_valid && out_word.too_many_rows;
    // An error word carries nothing but its two flags.
    assign err_word_ok = out_word.last_row && (out_word.row_bytes == '0)
                         && (out_word.src_offset == '0) && (out_word.dst_offset == '0);

    `CHK_NEXT(a_out_hold, out_held, out_valid && $stable(out_word), "stalled output word changed")
    `CHK_ASSERT(a_err_word, !err_word || err_word_ok, "malformed error word")
    `CHK_NEXT(a_busy_after_accept, in_accept, in_stall, "input open right after a request")

endmodule

bind strided_region_copy_address_gen_top srcag_checker u_srcag_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);
